[src/rgb3_pkg.sv]
// Shared types and constants of the RGB 3x3 replicate-border convolution block.
package rgb3_pkg;

   localparam int unsigned CHAN_BITS    = 8;
   localparam int unsigned KROW_BITS    = 48;
   localparam int unsigned WFIELD_BITS  = 12;
   localparam int unsigned HFIELD_BITS  = 13;
   localparam int unsigned ROW_BITS     = 13;

   localparam logic [WFIELD_BITS-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [HFIELD_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [HFIELD_BITS-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam logic [KROW_BITS-1:0]   KTOP_RESET   = 48'd0;
   localparam logic [KROW_BITS-1:0]   KMID_RESET   = 48'd16777216;
   localparam logic [KROW_BITS-1:0]   KBOT_RESET   = 48'd0;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   typedef enum logic [2:0] {
      CSR_WIDTH  = 3'd0,
      CSR_HEIGHT = 3'd1,
      CSR_KTOP   = 3'd2,
      CSR_KMID   = 3'd3,
      CSR_KBOT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   typedef struct packed {
      logic emit;
      logic wrap;
      logic top_rep;
      logic bot_rep;
      logic left_rep;
      logic last;
   } pos_type;

   // p[i][j]: i is the row (0 = above), j the column (0 = left)
   typedef struct packed {
      logic                  valid;
      logic                  last;
      pixel_type [2:0][2:0]  p;
   } nbhd_type;

   typedef struct packed {
      logic      valid;
      logic      last;
      pixel_type pix;
   } result_type;

   typedef struct packed {
      logic      last;
      pixel_type pix;
   } out_entry_type;

endpackage

[src/rgb_conv3x3_replicate.sv]
// Top level: RGB888 3x3 correlation with replicated borders, registers and result queue.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_type, req_pix_red/green/blue
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_red/green/blue, rsp_frame_last
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// One transaction per clock while req_stall is low; the line store RAM is read and written at most once a cycle.
// A result passes the stage-1, window, product, row-sum and result registers, then the result queue.
// Synchronous reset clears position, pipeline valids and queue; the line store is not cleared.
// A two-entry result queue absorbs rsp_stall; req_stall rises only when it is full.
module rgb_conv3x3_replicate #(
   parameter int unsigned MAX_WIDTH = 2048,
   parameter int unsigned COEF_BITS = 16,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [rgb3_pkg::CHAN_BITS-1:0]     req_pix_red,
   input  logic [rgb3_pkg::CHAN_BITS-1:0]     req_pix_green,
   input  logic [rgb3_pkg::CHAN_BITS-1:0]     req_pix_blue,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rgb3_pkg::CHAN_BITS-1:0]     rsp_out_red,
   output logic [rgb3_pkg::CHAN_BITS-1:0]     rsp_out_green,
   output logic [rgb3_pkg::CHAN_BITS-1:0]     rsp_out_blue,
   output logic                               rsp_frame_last,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [2:0]                         csr_index,
   input  logic [rgb3_pkg::KROW_BITS-1:0]     csr_wdata
);

   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CW = (WW > rgb3_pkg::WFIELD_BITS) ? WW : rgb3_pkg::WFIELD_BITS;
   localparam int unsigned HB = rgb3_pkg::HFIELD_BITS;

   function automatic logic [WW-1:0] clamp_w(input logic [rgb3_pkg::WFIELD_BITS-1:0] w);
      logic [WW-1:0] r;
      if (w == '0) begin
         r = WW'(1);
      end else if (CW'(w) > CW'(MAX_WIDTH)) begin
         r = WW'(MAX_WIDTH);
      end else begin
         r = WW'(w);
      end
      return r;
   endfunction

   function automatic logic [HB-1:0] clamp_h(input logic [HB-1:0] h);
      logic [HB-1:0] r;
      if (h == '0) begin
         r = HB'(1);
      end else if (h > rgb3_pkg::HEIGHT_LIMIT) begin
         r = rgb3_pkg::HEIGHT_LIMIT;
      end else begin
         r = h;
      end
      return r;
   endfunction

   logic [WW-1:0]                           eff_w_ff;
   logic [HB-1:0]                           eff_h_ff;
   logic [2:0][rgb3_pkg::KROW_BITS-1:0]     kern_ff;
   logic                                    restart;
   logic                                    adv;
   logic                                    req_accept;
   rgb3_pkg::pixel_type                     req_pix;
   rgb3_pkg::nbhd_type                      nb;
   rgb3_pkg::result_type                    res;

   rgb3_pkg::out_entry_type                 q_ff [2];
   logic                                    wp_ff, rp_ff;
   logic [1:0]                              cnt_ff, cnt_in;
   logic                                    push, pop;

   // register file
   assign csr_ready = 1'b1;

   always_comb begin
      restart = 1'b0;
      if (csr_valid) begin
         unique case (rgb3_pkg::csr_index_type'(csr_index))
            rgb3_pkg::CSR_WIDTH,
            rgb3_pkg::CSR_HEIGHT: restart = 1'b1;
            rgb3_pkg::CSR_KTOP,
            rgb3_pkg::CSR_KMID,
            rgb3_pkg::CSR_KBOT:   restart = 1'b0;
            default:              restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff   <= clamp_w(rgb3_pkg::WIDTH_RESET);
         eff_h_ff   <= clamp_h(rgb3_pkg::HEIGHT_RESET);
         kern_ff[0] <= rgb3_pkg::KTOP_RESET;
         kern_ff[1] <= rgb3_pkg::KMID_RESET;
         kern_ff[2] <= rgb3_pkg::KBOT_RESET;
      end else if (csr_valid) begin
         unique case (rgb3_pkg::csr_index_type'(csr_index))
            rgb3_pkg::CSR_WIDTH:  eff_w_ff   <= clamp_w(csr_wdata[rgb3_pkg::WFIELD_BITS-1:0]);
            rgb3_pkg::CSR_HEIGHT: eff_h_ff   <= clamp_h(csr_wdata[HB-1:0]);
            rgb3_pkg::CSR_KTOP:   kern_ff[0] <= csr_wdata;
            rgb3_pkg::CSR_KMID:   kern_ff[1] <= csr_wdata;
            rgb3_pkg::CSR_KBOT:   kern_ff[2] <= csr_wdata;
            default:              kern_ff    <= kern_ff;
         endcase
      end
   end

   // whole pipeline advances together while the queue has room
   assign adv        = (cnt_ff != 2'd2);
   assign req_stall  = !adv;
   assign req_accept = req_valid && adv;

   always_comb begin
      req_pix.red   = req_pix_red;
      req_pix.green = req_pix_green;
      req_pix.blue  = req_pix_blue;
   end

   rgb3_linebuf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_linebuf (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .restart   (restart),
      .eff_w     (eff_w_ff),
      .eff_h     (eff_h_ff),
      .in_accept (req_accept),
      .in_type   (req_type),
      .in_pix    (req_pix),
      .nb_out    (nb)
   );

   rgb3_mac #(
      .COEF_BITS (COEF_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .nb_in   (nb),
      .kernel  (kern_ff),
      .res_out (res)
   );

   // result queue
   assign push = adv && res.valid;
   assign pop  = (cnt_ff != 2'd0) && !rsp_stall;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (pop) begin
            rp_ff <= !rp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff].last <= res.last;
         q_ff[wp_ff].pix  <= res.pix;
      end
   end

   assign rsp_valid      = (cnt_ff != 2'd0);
   assign rsp_out_red    = q_ff[rp_ff].pix.red;
   assign rsp_out_green  = q_ff[rp_ff].pix.green;
   assign rsp_out_blue   = q_ff[rp_ff].pix.blue;
   assign rsp_frame_last = q_ff[rp_ff].last;

   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   a_queue_ptrs : assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("result queue pointers disagree with count");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      res.valid && cnt_ff == 2'd2 |=> $stable(res.valid) && res.valid)
      else $error("pending result dropped while the queue was full");

endmodule

[src/rgb3_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module rgb3_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                           clock,
   input  logic                                           wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                               wr_data,
   input  logic                                           rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                               rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rgb3_linebuf.sv]
// Frame position tracking, two-row line store with forwarding and the 3x3 window.
module rgb3_linebuf #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  restart,
   input  logic [$clog2(MAX_WIDTH + 1)-1:0]      eff_w,
   input  logic [rgb3_pkg::ROW_BITS-1:0]         eff_h,
   input  logic                                  in_accept,
   input  logic                                  in_type,
   input  rgb3_pkg::pixel_type                   in_pix,
   output rgb3_pkg::nbhd_type                    nb_out
);

   localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RB = rgb3_pkg::ROW_BITS;
   localparam int unsigned PB = $bits(rgb3_pkg::pixel_type);

   typedef struct packed {
      rgb3_pkg::pos_type   pos;
      logic [AW-1:0]       x;
      rgb3_pkg::pixel_type pix;
      logic                fwd;
      rgb3_pkg::pixel_type fwd_up;
      rgb3_pkg::pixel_type fwd_lo;
   } stage_type;

   logic [AW-1:0]       col_ff, col_in;
   logic [RB-1:0]       row_ff, row_in;
   logic [WW-1:0]       col_next;
   logic [RB:0]         h_plus1;
   logic [RB:0]         row_wide;
   rgb3_pkg::pos_type   pos;
   rgb3_pkg::pixel_type pix_in;

   logic                s1_valid_ff;
   stage_type           s1_ff;
   logic [2*PB-1:0]     rd_data;
   rgb3_pkg::pixel_type up_eff, lo_eff;
   rgb3_pkg::column_type new_col;
   rgb3_pkg::column_type win_ff [3];
   rgb3_pkg::column_type sel_col [3];
   rgb3_pkg::nbhd_type   nb_ff;

   // position of the incoming transaction
   always_comb begin
      col_next     = WW'(col_ff) + WW'(1);
      h_plus1      = {1'b0, eff_h} + (RB+1)'(1);
      row_wide     = {1'b0, row_ff};
      pos.wrap     = (col_ff == '0);
      pos.emit     = (row_ff >= RB'(2)) || ((row_ff == RB'(1)) && !pos.wrap);
      pos.top_rep  = pos.wrap ? (row_ff == RB'(2)) : (row_ff == RB'(1));
      pos.bot_rep  = pos.wrap ? (row_wide == h_plus1) : (row_ff == eff_h);
      pos.left_rep = pos.wrap ? (eff_w == WW'(1)) : (col_ff == AW'(1));
      pos.last     = pos.wrap && (row_wide == h_plus1);
      pix_in       = (in_type == rgb3_pkg::REQ_FLUSH) ? '0 : in_pix;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (in_accept) begin
         if (pos.emit && pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next == eff_w) begin
            col_in = '0;
            row_in = row_ff + RB'(1);
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: upper row in the high half, lower row in the low half
   rgb3_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (adv && s1_valid_ff),
      .wr_addr (s1_ff.x),
      .wr_data ({lo_eff, s1_ff.pix}),
      .rd_en   (adv),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      up_eff      = s1_ff.fwd ? s1_ff.fwd_up : rgb3_pkg::pixel_type'(rd_data[2*PB-1:PB]);
      lo_eff      = s1_ff.fwd ? s1_ff.fwd_lo : rgb3_pkg::pixel_type'(rd_data[PB-1:0]);
      new_col.top = up_eff;
      new_col.mid = lo_eff;
      new_col.bot = s1_ff.pix;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_accept;
      end
   end

   // forward the pending write when it targets the entry being read
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff.pos    <= pos;
         s1_ff.x      <= col_ff;
         s1_ff.pix    <= pix_in;
         s1_ff.fwd    <= s1_valid_ff && (s1_ff.x == col_ff);
         s1_ff.fwd_up <= lo_eff;
         s1_ff.fwd_lo <= s1_ff.pix;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= new_col;
      end
   end

   // replicate edges: left and right columns, then top and bottom rows
   always_comb begin
      sel_col[0] = s1_ff.pos.left_rep ? win_ff[2] : win_ff[1];
      sel_col[1] = win_ff[2];
      sel_col[2] = s1_ff.pos.wrap ? win_ff[2] : new_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nb_ff <= '0;
      end else if (adv) begin
         nb_ff.valid <= s1_valid_ff && s1_ff.pos.emit;
         nb_ff.last  <= s1_ff.pos.last;
         for (int j = 0; j < 3; j++) begin
            nb_ff.p[0][j] <= s1_ff.pos.top_rep ? sel_col[j].mid : sel_col[j].top;
            nb_ff.p[1][j] <= sel_col[j].mid;
            nb_ff.p[2][j] <= s1_ff.pos.bot_rep ? sel_col[j].mid : sel_col[j].bot;
         end
      end
   end

   assign nb_out = nb_ff;

   a_col_in_row : assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < eff_w)
      else $error("column position beyond the row width");

   a_last_bottom : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.pos.emit && s1_ff.pos.last |-> s1_ff.pos.bot_rep && s1_ff.pos.wrap)
      else $error("frame end outside the bottom row wrap");

   a_fwd_same_entry : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ff.fwd |-> s1_ff.x == $past(s1_ff.x))
      else $error("forwarded data from a different line store entry");

endmodule

[src/rgb3_mac.sv]
// Per-channel 3x3 multiply, accumulate, clamp and round pipeline.
module rgb3_mac #(
   parameter int unsigned COEF_BITS = 16,
   parameter int unsigned FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    adv,
   input  rgb3_pkg::nbhd_type                      nb_in,
   input  logic [2:0][rgb3_pkg::KROW_BITS-1:0]     kernel,
   output rgb3_pkg::result_type                    res_out
);

   localparam int unsigned CB = rgb3_pkg::CHAN_BITS;
   localparam int unsigned PW = COEF_BITS + CB + 1;
   localparam int unsigned SW = PW + 2;
   localparam int unsigned TW = PW + 4;
   localparam logic signed [TW-1:0] ACC_TOP  = TW'(255) << FRAC_BITS;
   localparam logic signed [TW-1:0] ACC_HALF = TW'(1) << (FRAC_BITS - 1);

   logic signed [COEF_BITS-1:0] coef [3][3];
   logic signed [PW-1:0]        prod_ff [3][3][3];
   logic signed [SW-1:0]        rsum_ff [3][3];
   logic                        p_valid_ff, p_last_ff;
   logic                        r_valid_ff, r_last_ff;
   logic signed [TW-1:0]        total [3];
   logic signed [TW-1:0]        clamped [3];
   logic        [TW-1:0]        rounded [3];
   logic [CB-1:0]               chan_out [3];
   rgb3_pkg::result_type        res_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            coef[i][j] = $signed(kernel[i][j*COEF_BITS +: COEF_BITS]);
         end
      end
   end

   // channel 0 is red, in the top byte of the pixel
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  prod_ff[ch][i][j] <=
                     $signed({1'b0, nb_in.p[i][j][(2-ch)*CB +: CB]}) * coef[i][j];
               end
            end
         end
         p_last_ff <= nb_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
               rsum_ff[ch][i] <= SW'(prod_ff[ch][i][0]) + SW'(prod_ff[ch][i][1])
                               + SW'(prod_ff[ch][i][2]);
            end
         end
         r_last_ff <= p_last_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         total[ch] = TW'(rsum_ff[ch][0]) + TW'(rsum_ff[ch][1]) + TW'(rsum_ff[ch][2]);
         if (total[ch] < 0) begin
            clamped[ch] = '0;
         end else if (total[ch] > ACC_TOP) begin
            clamped[ch] = ACC_TOP;
         end else begin
            clamped[ch] = total[ch];
         end
         rounded[ch]  = clamped[ch] + ACC_HALF;
         chan_out[ch] = rounded[ch][FRAC_BITS +: CB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         r_valid_ff   <= 1'b0;
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         p_valid_ff   <= nb_in.valid;
         r_valid_ff   <= p_valid_ff;
         res_ff.valid <= r_valid_ff;
      end
      if (adv) begin
         res_ff.last      <= r_last_ff;
         res_ff.pix.red   <= chan_out[0];
         res_ff.pix.green <= chan_out[1];
         res_ff.pix.blue  <= chan_out[2];
      end
   end

   assign res_out = res_ff;

endmodule
